// File: rtl/lge_pkg.sv
`default_nettype none
package lge_pkg;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int DIM_W = 7;
  localparam int ADDR_W = ROW_W + 1;
  localparam int DEPTH = 2 * MAX_ROWS;
  localparam int CFG_IDX_W = 4;
  localparam int IN_W = 16;
  localparam int OUT_W = 8;

  typedef logic [MAX_COLS-1:0] row_t;
  typedef logic [DIM_W-1:0] dim_t;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = CFG_IDX_W'(1);

  localparam dim_t DIM_RESET = DIM_W'(64);

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CELL_RD,
    ST_CELL_MOD,
    ST_ADV,
    ST_FIN
  } state_e;

endpackage
`default_nettype wire

// File: rtl/lge_ram.sv
`default_nettype none
module lge_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: rtl/lge_row_rule.sv
`default_nettype none
module lge_row_rule (
  input  wire logic [lge_pkg::MAX_COLS-1:0] up_i,
  input  wire logic [lge_pkg::MAX_COLS-1:0] mid_i,
  input  wire logic [lge_pkg::MAX_COLS-1:0] dn_i,
  input  wire logic [lge_pkg::DIM_W-1:0]    width_i,
  output      logic [lge_pkg::MAX_COLS-1:0] row_o
);
  import lge_pkg::*;

  logic [COL_W-1:0] wlast;
  logic [DIM_W-1:0] wm1;

  assign wm1 = width_i - DIM_W'(1);
  assign wlast = wm1[COL_W-1:0];

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_lane
    logic ul, ur, ml, mr, dl, dr;
    logic [3:0] n;

    if (c == 0) begin : g_first
      assign ul = up_i[wlast];
      assign ml = mid_i[wlast];
      assign dl = dn_i[wlast];
    end else begin : g_inner_l
      assign ul = up_i[c-1];
      assign ml = mid_i[c-1];
      assign dl = dn_i[c-1];
    end

    if (c == MAX_COLS - 1) begin : g_last
      assign ur = up_i[0];
      assign mr = mid_i[0];
      assign dr = dn_i[0];
    end else begin : g_inner_r
      assign ur = (wlast == COL_W'(c)) ? up_i[0] : up_i[c+1];
      assign mr = (wlast == COL_W'(c)) ? mid_i[0] : mid_i[c+1];
      assign dr = (wlast == COL_W'(c)) ? dn_i[0] : dn_i[c+1];
    end

    assign n = 4'(ul) + 4'(up_i[c]) + 4'(ur) + 4'(ml) + 4'(mr)
             + 4'(dl) + 4'(dn_i[c]) + 4'(dr);

    assign row_o[c] = (DIM_W'(c) < width_i) &&
                      ((mid_i[c] && n == 4'd2) || n == 4'd3);
  end

endmodule
`default_nettype wire

// File: rtl/toroidal_life_grid_engine.sv
`default_nettype none
// Cell write/read runs ST_CELL_RD, ST_CELL_MOD, ST_FIN; opcode 3 goes to ST_FIN.
// Advance one generation: one row read per cycle from
// the row-wide grid RAM, two rows of lead-in, then one row write per cycle.
// Throughput: one item at a time; the next input is taken while a result waits.
// Reset: rst_ni clears row valid bits (all cells read dead), active buffer to 0,
// grid_width and grid_height to 64; no clearing pass is needed.
module toroidal_life_grid_engine (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // {cell_in, row, col, opcode} from bit 0 up: opcode[1:0] col[7:2] row[13:8] cell_in[14]
  input  wire logic [lge_pkg::IN_W-1:0]        s_axis_tdata,
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  // cell_out[0] active_buffer[1]
  output      logic [lge_pkg::OUT_W-1:0]       m_axis_tdata,
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  input  wire logic                            cfg_valid_i,
  output      logic                            cfg_ready_o,
  input  wire logic [lge_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [lge_pkg::DIM_W-1:0]       cfg_data_i
);
  import lge_pkg::*;

  state_e state_q, state_d;

  dim_t w_cfg_q, h_cfg_q;
  dim_t w_eff, h_eff, hm1;
  logic cur_q, cur_d;
  logic [DEPTH-1:0] valid_q, valid_d;

  op_e op_q;
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic cin_q, inside_q, res_cell_q, res_cell_d;

  dim_t k_q, k_d, rd_k_q;
  logic rd_pend_q, rd_vld_q;
  row_t up_q, mid_q, dn_q;
  logic wr_pend_q;
  logic [ROW_W-1:0] wr_row_q;

  logic out_valid_q;
  logic [1:0] out_data_q;

  logic in_xfer, out_load, adv_issue, adv_done, in_inside;
  logic ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  row_t ram_wdata, ram_rdata, rd_row, new_row, bit_mask;
  logic [ROW_W-1:0] adv_rrow;
  dim_t rd_k_m2;
  op_e in_op;
  logic [COL_W-1:0] in_col;
  logic [ROW_W-1:0] in_row;

  assign in_op  = op_e'(s_axis_tdata[1:0]);
  assign in_col = s_axis_tdata[7:2];
  assign in_row = s_axis_tdata[13:8];

  assign w_eff = (w_cfg_q == '0) ? DIM_W'(1) :
                 (w_cfg_q > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : w_cfg_q;
  assign h_eff = (h_cfg_q == '0) ? DIM_W'(1) :
                 (h_cfg_q > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : h_cfg_q;
  assign hm1 = h_eff - DIM_W'(1);

  assign in_inside = (DIM_W'(in_col) < w_eff) && (DIM_W'(in_row) < h_eff);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign out_load = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);
  assign cfg_ready_o = 1'b1;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = {{(OUT_W-2){1'b0}}, out_data_q};

  assign rd_row = rd_vld_q ? ram_rdata : '0;
  assign bit_mask = row_t'(1) << col_q;
  assign rd_k_m2 = rd_k_q - DIM_W'(2);

  assign adv_issue = (state_q == ST_ADV) && (k_q <= h_eff + DIM_W'(1));
  assign adv_done = (state_q == ST_ADV) && wr_pend_q && (wr_row_q == hm1[ROW_W-1:0]);

  always_comb begin
    if (k_q == '0) begin
      adv_rrow = hm1[ROW_W-1:0];
    end else if (k_q == h_eff + DIM_W'(1)) begin
      adv_rrow = '0;
    end else begin
      adv_rrow = ROW_W'(k_q - DIM_W'(1));
    end
  end

  lge_row_rule u_rule (
    .up_i   (up_q),
    .mid_i  (mid_q),
    .dn_i   (dn_q),
    .width_i(w_eff),
    .row_o  (new_row)
  );

  lge_ram #(
    .WIDTH(MAX_COLS),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (in_op)
            OP_WRITE, OP_READ: state_d = ST_CELL_RD;
            OP_ADVANCE:        state_d = ST_ADV;
            OP_NOP:            state_d = ST_FIN;
            default:           state_d = ST_FIN;
          endcase
        end
      end
      ST_CELL_RD:  state_d = ST_CELL_MOD;
      ST_CELL_MOD: state_d = ST_FIN;
      ST_ADV: begin
        if (adv_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_re = 1'b0;
    ram_raddr = {cur_q, row_q};
    ram_we = 1'b0;
    ram_waddr = {cur_q, row_q};
    ram_wdata = (rd_row & ~bit_mask) | ({MAX_COLS{cin_q}} & bit_mask);
    valid_d = valid_q;
    cur_d = cur_q;
    k_d = k_q;
    res_cell_d = res_cell_q;
    unique case (state_q)
      ST_IDLE: begin
        res_cell_d = 1'b0;
        k_d = '0;
        if (in_xfer && in_op == OP_ADVANCE) begin
          for (int r = 0; r < MAX_ROWS; r++) begin
            valid_d[{~cur_q, ROW_W'(r)}] = 1'b0;
          end
        end
      end
      ST_CELL_RD: begin
        ram_re = 1'b1;
      end
      ST_CELL_MOD: begin
        if (op_q == OP_WRITE && inside_q) begin
          ram_we = 1'b1;
          valid_d[{cur_q, row_q}] = 1'b1;
        end
        res_cell_d = (op_q == OP_READ) && inside_q && rd_row[col_q];
      end
      ST_ADV: begin
        ram_raddr = {cur_q, adv_rrow};
        ram_re = adv_issue;
        if (adv_issue) begin
          k_d = k_q + DIM_W'(1);
        end
        ram_waddr = {~cur_q, wr_row_q};
        ram_wdata = new_row;
        if (wr_pend_q) begin
          ram_we = 1'b1;
          valid_d[{~cur_q, wr_row_q}] = 1'b1;
        end
        if (adv_done) begin
          cur_d = ~cur_q;
        end
      end
      ST_FIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      w_cfg_q <= DIM_RESET;
      h_cfg_q <= DIM_RESET;
      cur_q <= 1'b0;
      valid_q <= '0;
      k_q <= '0;
      rd_pend_q <= 1'b0;
      wr_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q <= cur_d;
      valid_q <= valid_d;
      k_q <= k_d;
      rd_pend_q <= adv_issue;
      wr_pend_q <= rd_pend_q && (rd_k_q >= DIM_W'(2));
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_GRID_WIDTH) begin
          w_cfg_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_GRID_HEIGHT) begin
          h_cfg_q <= cfg_data_i;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_cell_q <= res_cell_d;
    if (in_xfer) begin
      op_q <= in_op;
      col_q <= in_col;
      row_q <= in_row;
      cin_q <= s_axis_tdata[14];
      inside_q <= in_inside;
    end
    if (ram_re) begin
      rd_vld_q <= valid_q[ram_raddr];
    end
    if (adv_issue) begin
      rd_k_q <= k_q;
    end
    if (rd_pend_q) begin
      up_q <= mid_q;
      mid_q <= dn_q;
      dn_q <= rd_row;
      wr_row_q <= rd_k_m2[ROW_W-1:0];
    end
    if (out_load) begin
      out_data_q <= {cur_q, res_cell_q};
    end
  end

endmodule
`default_nettype wire
